// ----- rtl/core/fdrf_pkg.sv -----
package fdrf_pkg;

    // width of the screen coordinates on the result word
    localparam int COORD_W = 13;

    // width of the window position fields
    localparam int POS_W = 12;

    // results kept per window, and the counter that tracks them
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W = 5;

    // scan sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SUM,
        ST_PICK,
        ST_SMALL_RD,
        ST_SMALL_EV,
        ST_BAND_RD,
        ST_BAND_EV,
        ST_SPLIT,
        ST_TROW_INIT,
        ST_TROW_RD,
        ST_TROW_EV,
        ST_WALK,
        ST_SPLIT_RET,
        ST_TRIM_INIT,
        ST_TRIM_RD,
        ST_TRIM_EV,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // where the trim sequence goes when its rectangle is out
    typedef enum logic [1:0] {
        RET_FINISH,
        RET_SPLIT,
        RET_WALK
    } ret_t;

endpackage

// ----- rtl/core/fdrf_ram.sv -----
module fdrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/fdrf_span.sv -----
module fdrf_span #(
    parameter int TILE_SIZE = 32,
    parameter int MAX_WIDTH = 128
) (
    input  logic [((MAX_WIDTH+TILE_SIZE-1)/TILE_SIZE)*(1+2*$clog2(TILE_SIZE))-1:0] row,
    input  logic [$clog2((MAX_WIDTH+TILE_SIZE-1)/TILE_SIZE+1)-1:0]               col_lo,
    input  logic [$clog2((MAX_WIDTH+TILE_SIZE-1)/TILE_SIZE+1)-1:0]               col_hi,
    output logic                                                                   hit,
    output logic [$clog2(MAX_WIDTH+TILE_SIZE)-1:0]                                 lo,
    output logic [$clog2(MAX_WIDTH+TILE_SIZE)-1:0]                                 hi
);

    localparam int NTC = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TB  = $clog2(TILE_SIZE);
    localparam int CW  = $clog2(NTC + 1);
    localparam int PXW = $clog2(MAX_WIDTH + TILE_SIZE);

    logic [NTC-1:0] in_span;

    // tile columns inside the span that hold a changed pixel
    always_comb
    begin
        for (int c = 0; c < NTC; c++)
        begin
            in_span[c] = row[c] && (CW'(c) >= col_lo) && (CW'(c) < col_hi);
        end
    end

    // leftmost and rightmost changed pixel of the row over the span
    always_comb
    begin
        hit = |in_span;
        lo  = '0;
        hi  = '0;
        for (int c = NTC - 1; c >= 0; c--)
        begin
            if (in_span[c])
            begin
                lo = PXW'(c * TILE_SIZE) + PXW'(row[NTC + c*TB +: TB]);
            end
        end
        for (int c = 0; c < NTC; c++)
        begin
            if (in_span[c])
            begin
                hi = PXW'(c * TILE_SIZE) + PXW'(row[NTC + NTC*TB + c*TB +: TB]);
            end
        end
    end

endmodule

// ----- rtl/core/framebuffer_damage_rectangle_finder_unit.sv -----
// pixels load at one word per cycle while in_ready is high; after the final pixel
//   the block summarizes the window, then walks rows, reading and then evaluating
//   each row (band pass, tile rows, and one pass per trimmed run)
// one window at a time; a result waits until the next is found or the scan ends
// reset: control state cleared, bytes_per_pixel is 4; the pixel and row stores are
//   not cleared
module framebuffer_damage_rectangle_finder_unit
    import fdrf_pkg::*;
#(
    parameter int TILE_SIZE  = 32,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         window_left,
    input  logic [11:0]         window_top,
    input  logic [7:0]          window_width,
    input  logic [7:0]          window_height,
    input  logic [31:0]         previous_pixel,
    input  logic [31:0]         current_pixel,
    input  logic                final_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  rect_left,
    output logic [COORD_W-1:0]  rect_top,
    output logic [COORD_W-1:0]  rect_right,
    output logic [COORD_W-1:0]  rect_bottom,
    output logic                nothing_changed,
    output logic                last_rect
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int PXW   = $clog2(MAX_WIDTH + TILE_SIZE);
    localparam int YW    = $clog2(MAX_HEIGHT + TILE_SIZE + 1);
    localparam int RAW   = $clog2(MAX_HEIGHT);
    localparam int NTC   = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int CW    = $clog2(NTC + 1);
    localparam int CIW   = (NTC > 1) ? $clog2(NTC) : 1;
    localparam int TB    = $clog2(TILE_SIZE);
    localparam int RW    = NTC * (1 + 2*TB);
    localparam int HALF  = TILE_SIZE / 2;

    // ---------------- configuration and geometry ----------------
    logic [2:0]         bpp_reg;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]   left_reg, top_reg;
    logic [PXW-1:0]     w_reg;
    logic [YW-1:0]      h_reg;
    logic [CW-1:0]      ncols_reg, ncols_next;
    logic [31:0]        pix_mask;

    logic               accept_in;
    logic               first_px;
    logic [PXW-1:0]     geo_w;
    logic [YW-1:0]      geo_h;
    logic [PW-1:0]      total;
    logic               px_we;

    state_t             state_reg, state_next;

    // compare mask from the byte count
    always_comb
    begin
        unique case (bpp_reg)
            3'd0, 3'd1: pix_mask = 32'h0000_00ff;
            3'd2:       pix_mask = 32'h0000_ffff;
            3'd3:       pix_mask = 32'h00ff_ffff;
            default:    pix_mask = 32'hffff_ffff;
        endcase
    end

    assign in_ready  = (state_reg == ST_LOAD);
    assign accept_in = in_valid && in_ready;
    assign first_px  = (pos_reg == '0);

    // window size, clamped, taken from the word on the first pixel
    always_comb
    begin
        int wi;
        int hi_i;
        wi   = int'(window_width);
        hi_i = int'(window_height);
        if (wi == 0)
        begin
            wi = 1;
        end
        if (wi > MAX_WIDTH)
        begin
            wi = MAX_WIDTH;
        end
        if (hi_i == 0)
        begin
            hi_i = 1;
        end
        if (hi_i > MAX_HEIGHT)
        begin
            hi_i = MAX_HEIGHT;
        end
        geo_w = first_px ? PXW'(wi) : w_reg;
        geo_h = first_px ? YW'(hi_i) : h_reg;
        total = PW'(int'(geo_w) * int'(geo_h));
    end

    assign px_we = accept_in && (pos_reg < total);

    // load position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept_in)
        begin
            if (final_pixel)
            begin
                pos_next = '0;
            end
            else if (px_we)
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg  <= 3'd4;
            pos_reg  <= '0;
            left_reg <= '0;
            top_reg  <= '0;
            w_reg    <= '0;
            h_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bpp_reg <= cfg_wdata;
            end
            pos_reg <= pos_next;
            if (accept_in && first_px)
            begin
                left_reg <= window_left;
                top_reg  <= window_top;
                w_reg    <= geo_w;
                h_reg    <= geo_h;
            end
        end
    end

    // ---------------- pixel difference store ----------------
    logic [AW-1:0]  iaddr_reg, iaddr_next;
    logic [31:0]    xr_rdata;

    fdrf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_xor_ram (
        .clk   (clk),
        .we    (px_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (previous_pixel ^ current_pixel),
        .raddr (iaddr_reg),
        .rdata (xr_rdata)
    );

    // ---------------- summary pass: one read per pixel ----------------
    logic [PXW-1:0] ix_reg, ix_next;
    logic [YW-1:0]  iy_reg, iy_next;
    logic [CW-1:0]  icol_reg, icol_next;
    logic [TB-1:0]  ioff_reg, ioff_next;
    logic           issue_done_reg, issue_done_next;
    logic           issue;
    logic           start_sum;

    logic           p_valid_reg;
    logic [CIW-1:0] p_col_reg;
    logic [TB-1:0]  p_off_reg;
    logic           p_end_reg;
    logic [RAW-1:0] p_row_reg;

    assign start_sum = accept_in && final_pixel;
    assign issue     = (state_reg == ST_SUM) && !issue_done_reg;

    // raster counters for the read side
    always_comb
    begin
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        icol_next       = icol_reg;
        ioff_next       = ioff_reg;
        iaddr_next      = iaddr_reg;
        issue_done_next = issue_done_reg;
        ncols_next      = ncols_reg;
        if (start_sum)
        begin
            ix_next         = '0;
            iy_next         = '0;
            icol_next       = '0;
            ioff_next       = '0;
            iaddr_next      = '0;
            issue_done_next = 1'b0;
        end
        else if (issue)
        begin
            iaddr_next = iaddr_reg + AW'(1);
            if (ix_reg == w_reg - PXW'(1))
            begin
                ncols_next = icol_reg + CW'(1);
                ix_next    = '0;
                icol_next  = '0;
                ioff_next  = '0;
                iy_next    = iy_reg + YW'(1);
                if (iy_reg == h_reg - YW'(1))
                begin
                    issue_done_next = 1'b1;
                end
            end
            else
            begin
                ix_next = ix_reg + PXW'(1);
                if (ioff_reg == TB'(TILE_SIZE - 1))
                begin
                    ioff_next = '0;
                    icol_next = icol_reg + CW'(1);
                end
                else
                begin
                    ioff_next = ioff_reg + TB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg         <= '0;
            iy_reg         <= '0;
            icol_reg       <= '0;
            ioff_reg       <= '0;
            iaddr_reg      <= '0;
            issue_done_reg <= 1'b1;
            ncols_reg      <= '0;
            p_valid_reg    <= 1'b0;
        end
        else
        begin
            ix_reg         <= ix_next;
            iy_reg         <= iy_next;
            icol_reg       <= icol_next;
            ioff_reg       <= ioff_next;
            iaddr_reg      <= iaddr_next;
            issue_done_reg <= issue_done_next;
            ncols_reg      <= ncols_next;
            p_valid_reg    <= issue;
        end
    end

    // tags that travel with the read
    always_ff @(posedge clk)
    begin
        p_col_reg <= icol_reg[CIW-1:0];
        p_off_reg <= ioff_reg;
        p_end_reg <= (ix_reg == w_reg - PXW'(1));
        p_row_reg <= iy_reg[RAW-1:0];
    end

    // per-row accumulation of changed tiles and their pixel extent
    logic [NTC-1:0] acc_any_reg, acc_any_next, acc_any_new;
    logic [TB-1:0]  acc_min_reg [NTC];
    logic [TB-1:0]  acc_max_reg [NTC];
    logic [TB-1:0]  acc_min_new [NTC];
    logic [TB-1:0]  acc_max_new [NTC];
    logic           px_diff;
    logic           row_we;
    logic [RW-1:0]  row_wdata;
    logic [RAW-1:0] row_raddr;
    logic [RW-1:0]  row_rdata;

    assign px_diff = |(xr_rdata & pix_mask);
    assign row_we  = p_valid_reg && p_end_reg;

    always_comb
    begin
        for (int c = 0; c < NTC; c++)
        begin
            acc_any_new[c] = acc_any_reg[c];
            acc_min_new[c] = acc_min_reg[c];
            acc_max_new[c] = acc_max_reg[c];
            if (p_valid_reg && px_diff && (p_col_reg == CIW'(c)))
            begin
                if (!acc_any_reg[c])
                begin
                    acc_min_new[c] = p_off_reg;
                end
                acc_max_new[c] = p_off_reg;
                acc_any_new[c] = 1'b1;
            end
        end
        acc_any_next = row_we ? '0 : acc_any_new;
    end

    // row summary word: any bits, then first offsets, then last offsets
    always_comb
    begin
        row_wdata = '0;
        for (int c = 0; c < NTC; c++)
        begin
            row_wdata[c]                        = acc_any_new[c];
            row_wdata[NTC + c*TB +: TB]         = acc_min_new[c];
            row_wdata[NTC + NTC*TB + c*TB +: TB] = acc_max_new[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_any_reg <= '0;
        end
        else
        begin
            acc_any_reg <= acc_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NTC; c++)
        begin
            acc_min_reg[c] <= acc_min_new[c];
            acc_max_reg[c] <= acc_max_new[c];
        end
    end

    fdrf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_HEIGHT)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (p_row_reg),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // ---------------- scan sequencer ----------------
    logic [YW-1:0]   y_reg, y_next;
    logic [YW-1:0]   bt_reg, bt_next;
    logic            bv_reg, bv_next;
    logic [YW-1:0]   sb_t_reg, sb_t_next;
    logic [YW-1:0]   sb_b_reg, sb_b_next;
    logic [YW-1:0]   ty_reg, ty_next;
    logic [YW-1:0]   tbb_reg, tbb_next;
    logic [YW-1:0]   ay_reg, ay_next;
    logic [NTC-1:0]  hit_reg, hit_next;
    logic [YW-1:0]   ctop_reg [NTC];
    logic [YW-1:0]   ctop_next [NTC];
    logic [CW-1:0]   cx_reg, cx_next;
    logic            run_reg, run_next;
    logic [CW-1:0]   rl_reg, rl_next;
    logic [YW-1:0]   rt_reg, rt_next;
    logic [CW-1:0]   tc_l_reg, tc_l_next;
    logic [CW-1:0]   tc_e_reg, tc_e_next;
    logic [YW-1:0]   tt_reg, tt_next;
    logic [YW-1:0]   tb_reg, tb_next;
    logic [YW-1:0]   tr_row_reg, tr_row_next;
    logic [YW-1:0]   last_reg, last_next;
    logic [PXW-1:0]  lo_reg, lo_next;
    logic [PXW-1:0]  hi_reg, hi_next;
    ret_t            ret_reg, ret_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0] pend_l_reg, pend_t_reg, pend_r_reg, pend_b_reg;
    logic [COORD_W-1:0] pend_l_next, pend_t_next, pend_r_next, pend_b_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_l_reg, out_t_reg, out_r_reg, out_b_reg;
    logic [COORD_W-1:0] out_l_next, out_t_next, out_r_next, out_b_next;
    logic               out_nc_reg, out_nc_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic [NTC-1:0]     r_any;
    logic               row_hit;
    logic               sp_hit;
    logic [PXW-1:0]     sp_lo, sp_hi;
    logic [PXW-1:0]     right_px;
    logic [YW-1:0]      ny;
    logic [YW-1:0]      ty_plus;
    logic [COORD_W-1:0] n_left, n_top, n_right, n_bottom;

    assign r_any    = row_rdata[NTC-1:0];
    assign row_hit  = |r_any;
    assign out_free = !out_valid_reg || out_ready;

    // row address for each kind of row pass
    always_comb
    begin
        unique case (state_reg)
            ST_TROW_RD: row_raddr = ay_reg[RAW-1:0];
            ST_TRIM_RD: row_raddr = tr_row_reg[RAW-1:0];
            default:    row_raddr = y_reg[RAW-1:0];
        endcase
    end

    fdrf_span #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_span (
        .row    (row_rdata),
        .col_lo (tc_l_reg),
        .col_hi (tc_e_reg),
        .hit    (sp_hit),
        .lo     (sp_lo),
        .hi     (sp_hi)
    );

    // trimmed run right edge, and the rectangle in screen coordinates
    always_comb
    begin
        right_px = PXW'(int'(tc_e_reg) * TILE_SIZE);
        if (right_px > w_reg)
        begin
            right_px = w_reg;
        end
        ty_plus  = ty_reg + YW'(TILE_SIZE);
        n_left   = COORD_W'(left_reg) + COORD_W'(lo_reg);
        n_top    = COORD_W'(top_reg) + COORD_W'(tt_reg);
        n_right  = COORD_W'(left_reg) + COORD_W'(hi_reg) + COORD_W'(1);
        n_bottom = COORD_W'(top_reg) + COORD_W'(last_reg) + COORD_W'(1);
    end

    // next state and datapath updates
    always_comb
    begin
        state_next      = state_reg;
        y_next          = y_reg;
        bt_next         = bt_reg;
        bv_next         = bv_reg;
        sb_t_next       = sb_t_reg;
        sb_b_next       = sb_b_reg;
        ty_next         = ty_reg;
        tbb_next        = tbb_reg;
        ay_next         = ay_reg;
        hit_next        = hit_reg;
        ctop_next       = ctop_reg;
        cx_next         = cx_reg;
        run_next        = run_reg;
        rl_next         = rl_reg;
        rt_next         = rt_reg;
        tc_l_next       = tc_l_reg;
        tc_e_next       = tc_e_reg;
        tt_next         = tt_reg;
        tb_next         = tb_reg;
        tr_row_next     = tr_row_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ret_next        = ret_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_l_next     = pend_l_reg;
        pend_t_next     = pend_t_reg;
        pend_r_next     = pend_r_reg;
        pend_b_next     = pend_b_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_l_next      = out_l_reg;
        out_t_next      = out_t_reg;
        out_r_next      = out_r_reg;
        out_b_next      = out_b_reg;
        out_nc_next     = out_nc_reg;
        out_last_next   = out_last_reg;
        ny              = y_reg + YW'(HALF);

        unique case (state_reg)
            ST_LOAD:
            begin
                if (start_sum)
                begin
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SUM;
                end
            end

            ST_SUM:
            begin
                if (issue_done_reg && !p_valid_reg)
                begin
                    state_next = ST_PICK;
                end
            end

            // small windows look for the first changed row only
            ST_PICK:
            begin
                y_next  = '0;
                bv_next = 1'b0;
                if (w_reg <= PXW'(TILE_SIZE) && h_reg <= YW'(TILE_SIZE))
                begin
                    state_next = ST_SMALL_RD;
                end
                else
                begin
                    state_next = ST_BAND_RD;
                end
            end

            ST_SMALL_RD:
            begin
                state_next = ST_SMALL_EV;
            end

            ST_SMALL_EV:
            begin
                if (row_hit)
                begin
                    tc_l_next  = '0;
                    tc_e_next  = CW'(1);
                    tt_next    = y_reg;
                    tb_next    = h_reg;
                    ret_next   = RET_FINISH;
                    state_next = ST_TRIM_INIT;
                end
                else if (y_reg + YW'(1) >= h_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    y_next     = y_reg + YW'(1);
                    state_next = ST_SMALL_RD;
                end
            end

            // band pass: a changed row opens a band and skips ahead
            ST_BAND_RD:
            begin
                state_next = ST_BAND_EV;
            end

            ST_BAND_EV:
            begin
                if (row_hit)
                begin
                    if (!bv_reg)
                    begin
                        bt_next = y_reg;
                        bv_next = 1'b1;
                    end
                    y_next = ny;
                    if (ny >= h_reg)
                    begin
                        sb_t_next  = bv_reg ? bt_reg : y_reg;
                        sb_b_next  = h_reg;
                        bv_next    = 1'b0;
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        state_next = ST_BAND_RD;
                    end
                end
                else if (bv_reg)
                begin
                    sb_t_next  = bt_reg;
                    sb_b_next  = y_reg;
                    bv_next    = 1'b0;
                    y_next     = y_reg + YW'(1);
                    state_next = ST_SPLIT;
                end
                else if (y_reg + YW'(1) >= h_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    y_next     = y_reg + YW'(1);
                    state_next = ST_BAND_RD;
                end
            end

            ST_SPLIT:
            begin
                if (w_reg <= PXW'(TILE_SIZE) && (sb_b_reg - sb_t_reg) <= YW'(TILE_SIZE))
                begin
                    tc_l_next  = '0;
                    tc_e_next  = CW'(1);
                    tt_next    = sb_t_reg;
                    tb_next    = sb_b_reg;
                    ret_next   = RET_SPLIT;
                    state_next = ST_TRIM_INIT;
                end
                else
                begin
                    ty_next    = sb_t_reg;
                    state_next = ST_TROW_INIT;
                end
            end

            // tile row: first changed row of each tile column
            ST_TROW_INIT:
            begin
                hit_next   = '0;
                ay_next    = ty_reg;
                tbb_next   = (ty_plus < sb_b_reg) ? ty_plus : sb_b_reg;
                state_next = ST_TROW_RD;
            end

            ST_TROW_RD:
            begin
                state_next = ST_TROW_EV;
            end

            ST_TROW_EV:
            begin
                for (int c = 0; c < NTC; c++)
                begin
                    if (r_any[c] && !hit_reg[c])
                    begin
                        hit_next[c]  = 1'b1;
                        ctop_next[c] = ay_reg;
                    end
                end
                ay_next = ay_reg + YW'(1);
                if (ay_reg + YW'(1) == tbb_reg)
                begin
                    cx_next    = '0;
                    run_next   = 1'b0;
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_TROW_RD;
                end
            end

            // runs of changed tiles along the tile row
            ST_WALK:
            begin
                if (cx_reg < ncols_reg)
                begin
                    cx_next = cx_reg + CW'(1);
                    if (hit_reg[cx_reg[CIW-1:0]])
                    begin
                        if (!run_reg)
                        begin
                            run_next = 1'b1;
                            rl_next  = cx_reg;
                            rt_next  = ctop_reg[cx_reg[CIW-1:0]];
                        end
                        else if (ctop_reg[cx_reg[CIW-1:0]] < rt_reg)
                        begin
                            rt_next = ctop_reg[cx_reg[CIW-1:0]];
                        end
                    end
                    else if (run_reg)
                    begin
                        run_next   = 1'b0;
                        tc_l_next  = rl_reg;
                        tc_e_next  = cx_reg;
                        tt_next    = rt_reg;
                        tb_next    = tbb_reg;
                        ret_next   = RET_WALK;
                        state_next = ST_TRIM_INIT;
                    end
                end
                else if (run_reg)
                begin
                    run_next   = 1'b0;
                    tc_l_next  = rl_reg;
                    tc_e_next  = ncols_reg;
                    tt_next    = rt_reg;
                    tb_next    = tbb_reg;
                    ret_next   = RET_WALK;
                    state_next = ST_TRIM_INIT;
                end
                else
                begin
                    ty_next = ty_plus;
                    if (ty_plus < sb_b_reg)
                    begin
                        state_next = ST_TROW_INIT;
                    end
                    else
                    begin
                        state_next = ST_SPLIT_RET;
                    end
                end
            end

            ST_SPLIT_RET:
            begin
                if (y_reg < h_reg)
                begin
                    state_next = ST_BAND_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            // trim: last changed row and horizontal extent over the run
            ST_TRIM_INIT:
            begin
                tr_row_next = tt_reg;
                last_next   = tt_reg;
                lo_next     = right_px - PXW'(1);
                hi_next     = PXW'(int'(tc_l_reg) * TILE_SIZE);
                state_next  = ST_TRIM_RD;
            end

            ST_TRIM_RD:
            begin
                state_next = ST_TRIM_EV;
            end

            ST_TRIM_EV:
            begin
                if (sp_hit)
                begin
                    last_next = tr_row_reg;
                    if (sp_lo < lo_reg)
                    begin
                        lo_next = sp_lo;
                    end
                    if (sp_hi > hi_reg)
                    begin
                        hi_next = sp_hi;
                    end
                end
                tr_row_next = tr_row_reg + YW'(1);
                if (tr_row_reg + YW'(1) == tb_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TRIM_RD;
                end
            end

            // one result held back so the final one can be marked
            ST_EMIT:
            begin
                if (count_reg >= CNT_W'(MAX_RESULTS) || !pend_valid_reg || out_free)
                begin
                    if (count_reg < CNT_W'(MAX_RESULTS))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_l_next     = pend_l_reg;
                            out_t_next     = pend_t_reg;
                            out_r_next     = pend_r_reg;
                            out_b_next     = pend_b_reg;
                            out_nc_next    = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_l_next     = n_left;
                        pend_t_next     = n_top;
                        pend_r_next     = n_right;
                        pend_b_next     = n_bottom;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    unique case (ret_reg)
                        RET_FINISH: state_next = ST_FINISH;
                        RET_SPLIT:  state_next = ST_SPLIT_RET;
                        RET_WALK:   state_next = ST_WALK;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_nc_next     = !pend_valid_reg;
                    out_l_next      = pend_valid_reg ? pend_l_reg : '0;
                    out_t_next      = pend_valid_reg ? pend_t_reg : '0;
                    out_r_next      = pend_valid_reg ? pend_r_reg : '0;
                    out_b_next      = pend_valid_reg ? pend_b_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            bv_reg         <= 1'b0;
            run_reg        <= 1'b0;
            hit_reg        <= '0;
            ret_reg        <= RET_FINISH;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bv_reg         <= bv_next;
            run_reg        <= run_next;
            hit_reg        <= hit_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // sequencer datapath registers
    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        bt_reg       <= bt_next;
        sb_t_reg     <= sb_t_next;
        sb_b_reg     <= sb_b_next;
        ty_reg       <= ty_next;
        tbb_reg      <= tbb_next;
        ay_reg       <= ay_next;
        ctop_reg     <= ctop_next;
        cx_reg       <= cx_next;
        rl_reg       <= rl_next;
        rt_reg       <= rt_next;
        tc_l_reg     <= tc_l_next;
        tc_e_reg     <= tc_e_next;
        tt_reg       <= tt_next;
        tb_reg       <= tb_next;
        tr_row_reg   <= tr_row_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pend_l_reg   <= pend_l_next;
        pend_t_reg   <= pend_t_next;
        pend_r_reg   <= pend_r_next;
        pend_b_reg   <= pend_b_next;
        out_l_reg    <= out_l_next;
        out_t_reg    <= out_t_next;
        out_r_reg    <= out_r_next;
        out_b_reg    <= out_b_next;
        out_nc_reg   <= out_nc_next;
        out_last_reg <= out_last_next;
    end

    // result word
    assign out_valid       = out_valid_reg;
    assign rect_left       = out_l_reg;
    assign rect_top        = out_t_reg;
    assign rect_right      = out_r_reg;
    assign rect_bottom     = out_b_reg;
    assign nothing_changed = out_nc_reg;
    assign last_rect       = out_last_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import fdrf_pkg::*;

    localparam int TILE = 32;
    localparam int MAXW = 128;
    localparam int MAXH = 128;
    localparam int DEPTH = MAXW * MAXH;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [11:0] left;
        logic [11:0] top;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [31:0] prev;
        logic [31:0] cur;
        logic        fin;
        bit          hold;
    } pixel_word_t;

    typedef struct {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic               none;
        logic               last;
    } damage_rect_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic [11:0] window_left;
    logic [11:0] window_top;
    logic [7:0] window_width;
    logic [7:0] window_height;
    logic [31:0] previous_pixel;
    logic [31:0] current_pixel;
    logic final_pixel;
    logic out_valid;
    logic out_ready;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_right;
    logic [COORD_W-1:0] rect_bottom;
    logic nothing_changed;
    logic last_rect;

    pixel_word_t pending_words[$];
    damage_rect_t expected_rects[$];
    damage_rect_t found_rects[$];
    int errors;
    int cycles;
    int idle_mode;

    // model copy of the block state
    bit [31:0] prev_mem[DEPTH];
    bit [31:0] cur_mem[DEPTH];
    int load_pos;
    int win_left;
    int win_top;
    int win_w;
    int win_h;
    logic [2:0] bpp_model;
    bit [31:0] cmp_mask;
    int rect_count;

    // generator view of which store entries have been loaded
    bit loaded[DEPTH];

    framebuffer_damage_rectangle_finder_unit #(
        .TILE_SIZE(TILE),
        .MAX_WIDTH(MAXW),
        .MAX_HEIGHT(MAXH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .window_left(window_left),
        .window_top(window_top),
        .window_width(window_width),
        .window_height(window_height),
        .previous_pixel(previous_pixel),
        .current_pixel(current_pixel),
        .final_pixel(final_pixel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rect_left(rect_left),
        .rect_top(rect_top),
        .rect_right(rect_right),
        .rect_bottom(rect_bottom),
        .nothing_changed(nothing_changed),
        .last_rect(last_rect)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // damage search, mirrors the block's scan rules
    function automatic bit pixel_changed(int x, int y);
        int i;
        i = y * win_w + x;
        if (x < 0 || y < 0 || i >= DEPTH)
            return 1'b0;
        return ((prev_mem[i] ^ cur_mem[i]) & cmp_mask) != 0;
    endfunction

    function automatic bit row_changed(int y, int x0, int x1);
        for (int x = x0; x < x1; x++)
            if (pixel_changed(x, y))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_rect(int l, int t, int r, int b);
        damage_rect_t d;
        if (rect_count < MAX_RESULTS)
        begin
            d.left = COORD_W'(l + win_left);
            d.top = COORD_W'(t + win_top);
            d.right = COORD_W'(r + win_left);
            d.bottom = COORD_W'(b + win_top);
            d.none = 1'b0;
            d.last = 1'b0;
            found_rects.push_back(d);
        end
        rect_count++;
    endfunction

    function automatic void trim_rect(int l, int t, int r, int b);
        int nb;
        int lo;
        int hi;
        nb = t + 1;
        lo = r - 1 - l;
        hi = 0;
        for (int y = b - 1; y > t; y--)
            if (row_changed(y, l, r))
            begin
                nb = y + 1;
                break;
            end
        for (int y = t; y < nb; y++)
        begin
            for (int x = l; x < r; x++)
                if (pixel_changed(x, y))
                begin
                    if (x - l < lo) lo = x - l;
                    break;
                end
            for (int x = r - 1; x >= l; x--)
                if (pixel_changed(x, y))
                begin
                    if (x - l > hi) hi = x - l;
                    break;
                end
        end
        push_rect(l + lo, t, l + hi + 1, nb);
    endfunction

    function automatic void split_into_tiles(int l, int t, int r, int b);
        int bb;
        int br;
        int ay;
        int run_left;
        int run_top;
        if (r - l <= TILE && b - t <= TILE)
        begin
            trim_rect(l, t, r, b);
            return;
        end
        for (int y = t; y < b; y += TILE)
        begin
            bb = (y + TILE < b) ? y + TILE : b;
            run_left = -1;
            run_top = 0;
            for (int x = l; x < r; x += TILE)
            begin
                br = (x + TILE < r) ? x + TILE : r;
                for (ay = y; ay < bb; ay++)
                    if (row_changed(ay, x, br))
                        break;
                if (ay < bb)
                begin
                    if (run_left < 0)
                    begin
                        run_left = x;
                        run_top = ay;
                    end
                    else if (ay < run_top)
                        run_top = ay;
                end
                else if (run_left >= 0)
                begin
                    trim_rect(run_left, run_top, x, bb);
                    run_left = -1;
                end
            end
            if (run_left >= 0)
                trim_rect(run_left, run_top, r, bb);
        end
    endfunction

    function automatic void scan_damage();
        int band_top;
        band_top = -1;
        if (win_w <= TILE && win_h <= TILE)
        begin
            for (int y = 0; y < win_h; y++)
                if (row_changed(y, 0, win_w))
                begin
                    trim_rect(0, y, win_w, win_h);
                    break;
                end
            return;
        end
        for (int y = 0; y < win_h; y++)
        begin
            if (row_changed(y, 0, win_w))
            begin
                if (band_top < 0) band_top = y;
                y += TILE / 2 - 1;
            end
            else if (band_top >= 0)
            begin
                split_into_tiles(0, band_top, win_w, y);
                band_top = -1;
            end
        end
        if (band_top >= 0)
            split_into_tiles(0, band_top, win_w, win_h);
    endfunction

    // load one accepted word, predict the rectangles on the final one
    function automatic void load_pixel(pixel_word_t p);
        int b;
        damage_rect_t d;
        if (load_pos == 0)
        begin
            win_w = (p.width == 0) ? 1 : (p.width > MAXW ? MAXW : int'(p.width));
            win_h = (p.height == 0) ? 1 : (p.height > MAXH ? MAXH : int'(p.height));
            win_left = int'(p.left);
            win_top = int'(p.top);
        end
        if (load_pos < win_w * win_h && load_pos < DEPTH)
        begin
            prev_mem[load_pos] = p.prev;
            cur_mem[load_pos] = p.cur;
            load_pos++;
        end
        if (!p.fin)
            return;
        load_pos = 0;
        b = (bpp_model == 0) ? 1 : int'(bpp_model);
        cmp_mask = (b >= 4) ? 32'hffff_ffff : (32'h1 << (8 * b)) - 1;
        rect_count = 0;
        found_rects.delete();
        scan_damage();
        if (found_rects.size() == 0)
        begin
            d = '{default: '0};
            d.none = 1'b1;
            d.last = 1'b1;
            expected_rects.push_back(d);
        end
        else
        begin
            found_rects[found_rects.size() - 1].last = 1'b1;
            foreach (found_rects[i])
                expected_rects.push_back(found_rects[i]);
        end
    endfunction

    // queue one window: density in per mille, extra words past the end,
    // early final only where every skipped entry was loaded before
    task automatic queue_window(int wr, int hr, int dens, int extra, bit early, bit hold);
        pixel_word_t p;
        int w;
        int h;
        int total;
        int count;
        int lane;
        w = (wr == 0) ? 1 : (wr > MAXW ? MAXW : wr);
        h = (hr == 0) ? 1 : (hr > MAXH ? MAXH : hr);
        total = w * h;
        count = total + extra;
        if (early && total > 1)
        begin
            count = $urandom_range(1, total - 1);
            for (int i = count; i < total; i++)
                if (!loaded[i])
                    count = total;
        end
        for (int i = 0; i < count; i++)
        begin
            p.left = 12'($urandom);
            p.top = 12'($urandom);
            p.width = 8'($urandom);
            p.height = 8'($urandom);
            if (i == 0)
            begin
                p.width = 8'(wr);
                p.height = 8'(hr);
            end
            p.prev = $urandom;
            p.cur = p.prev;
            if ($urandom_range(0, 999) < dens)
            begin
                lane = $urandom_range(0, 3);
                p.cur = p.prev ^ (32'($urandom_range(1, 255)) << (8 * lane));
            end
            p.fin = (i == count - 1);
            p.hold = hold && (i == 0);
            if (i < total)
                loaded[i] = 1'b1;
            pending_words.push_back(p);
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_rects.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                load_pixel('{window_left, window_top, window_width, window_height,
                             previous_pixel, current_pixel, final_pixel, 1'b0});
            if (pending_words.size() != 0
                && !(idle_mode == 0 && $urandom_range(0, 99) < 18)
                && !(idle_mode == 1 && $urandom_range(0, 99) < 52)
                && !(pending_words[0].hold && expected_rects.size() != 0))
            begin
                window_left <= pending_words[0].left;
                window_top <= pending_words[0].top;
                window_width <= pending_words[0].width;
                window_height <= pending_words[0].height;
                previous_pixel <= pending_words[0].prev;
                current_pixel <= pending_words[0].cur;
                final_pixel <= pending_words[0].fin;
                void'(pending_words.pop_front());
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rects.size() == 0)
                begin
                    $error("unexpected result word");
                    errors++;
                end
                else
                begin
                    damage_rect_t e;
                    e = expected_rects.pop_front();
                    if (rect_left !== e.left)
                    begin
                        $error("rect_left exp %0d got %0d", e.left, rect_left);
                        errors++;
                    end
                    if (rect_top !== e.top)
                    begin
                        $error("rect_top exp %0d got %0d", e.top, rect_top);
                        errors++;
                    end
                    if (rect_right !== e.right)
                    begin
                        $error("rect_right exp %0d got %0d", e.right, rect_right);
                        errors++;
                    end
                    if (rect_bottom !== e.bottom)
                    begin
                        $error("rect_bottom exp %0d got %0d", e.bottom, rect_bottom);
                        errors++;
                    end
                    if (nothing_changed !== e.none)
                    begin
                        $error("nothing_changed exp %0d got %0d", e.none, nothing_changed);
                        errors++;
                    end
                    if (last_rect !== e.last)
                    begin
                        $error("last_rect exp %0d got %0d", e.last, last_rect);
                        errors++;
                    end
                end
            end
            if (idle_mode == 0)
                out_ready <= ($urandom_range(0, 99) >= 52);
            else if (idle_mode == 1)
                out_ready <= ($urandom_range(0, 99) >= 18);
            else
                out_ready <= 1'b1;
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [2:0] bpp_plan[9];
        int w;
        int h;
        bpp_plan = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
        errors = 0;
        cycles = 0;
        idle_mode = 0;
        load_pos = 0;
        win_left = 0;
        win_top = 0;
        win_w = 0;
        win_h = 0;
        bpp_model = 3'd4;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        window_left = '0;
        window_top = '0;
        window_width = '0;
        window_height = '0;
        previous_pixel = '0;
        current_pixel = '0;
        final_pixel = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: tiny windows, zero sizes, extreme corners, extra words, an early final
        queue_window(1, 1, 0, 0, 0, 0);
        queue_window(0, 0, 1000, 0, 0, 0);
        pending_words[$].left = 12'hfff;
        pending_words[$].top = 12'hfff;
        pending_words[$].width = 8'd0;
        pending_words[$].height = 8'd0;
        queue_window(3, 3, 400, 0, 0, 0);
        queue_window(2, 4, 1000, 3, 0, 0);
        queue_window(4, 2, 1000, 0, 1, 0);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                cfg_we <= 1'b1;
                cfg_wdata <= bpp_plan[ph];
                @(posedge clk);
                cfg_we <= 1'b0;
                bpp_model = bpp_plan[ph];
            end
            idle_mode = ph / 3;
            // one wide single-row window split into tile columns, one tall band window
            if (ph == 2)
                queue_window(34, 1, 100, 0, 0, 0);
            if (ph == 5)
                queue_window(1, 33, 150, 0, 0, 0);
            for (int k = 0; k < 2; k++)
            begin
                w = $urandom_range(0, 4);
                h = $urandom_range(0, 4);
                queue_window(w, h, $urandom_range(0, 3) * 150,
                             ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                             $urandom_range(0, 5) == 0, ph == 1 && k == 0);
            end
        end
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
